FILE: design/ric_pkg.sv
package ric_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = 5;
  localparam int DEV_W   = 16;
  localparam int INO_W   = 32;
  localparam int REF_W   = 16;
  localparam int STAT_W  = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [REF_W-1:0] REF_MAX  = {REF_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    RS_HIT       = 3'd0,
    RS_MISS      = 3'd1,
    RS_RELEASED  = 3'd2,
    RS_REL_WB    = 3'd3,
    RS_REL_FREE  = 3'd4,
    RS_NOT_HELD  = 3'd5,
    RS_FULL      = 3'd6,
    RS_BAD_TAG   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_PICK,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic [REF_W-1:0] refs;
    logic             dirty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic clr;
    logic scan;
    logic rd_tgt;
    logic eval;
    logic imm;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic dec_scan;
    logic dec_slot;
    logic pick_ok;
    logic out_free;
  } sts_t;

endpackage

FILE: design/ric_in_if.sv
interface ric_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [ric_pkg::DEV_W-1:0]  device_id;
  logic [ric_pkg::INO_W-1:0]  inode_number;
  logic [ric_pkg::SLOT_W-1:0] slot;
  logic                       links_zero;

  modport source (output valid, opcode, device_id, inode_number, slot, links_zero,
                  input ready);
  modport sink (input valid, opcode, device_id, inode_number, slot, links_zero,
                output ready);
endinterface

FILE: design/ric_out_if.sv
interface ric_out_if;
  logic                       valid;
  logic                       ready;
  logic [ric_pkg::STAT_W-1:0] status;
  logic [ric_pkg::SLOT_W-1:0] slot_out;
  logic                       victim_writeback;
  logic [ric_pkg::DEV_W-1:0]  victim_device;
  logic [ric_pkg::INO_W-1:0]  victim_inode;
  logic [ric_pkg::REF_W-1:0]  ref_count;

  modport source (output valid, status, slot_out, victim_writeback, victim_device,
                  victim_inode, ref_count, input ready);
  modport sink (input valid, status, slot_out, victim_writeback, victim_device,
                victim_inode, ref_count, output ready);
endinterface

FILE: design/ric_ram.sv
module ric_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ric_ctrl.sv
module ric_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ric_pkg::sts_t sts,
  output ric_pkg::cmd_t cmd
);
  import ric_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (sts.dec_scan) state_nxt = S_SCAN;
        else if (sts.dec_slot) state_nxt = S_READ;
        else state_nxt = S_FINISH;
      end
      S_SCAN:     if (sts.scan_last) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_PICK;
      S_PICK:     state_nxt = sts.pick_ok ? S_READ : S_FINISH;
      S_READ:     state_nxt = S_EVAL;
      S_EVAL:     state_nxt = S_FINISH;
      S_FINISH:   if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: cmd.imm = !sts.dec_scan && !sts.dec_slot;
      S_SCAN:   cmd.scan = 1'b1;
      S_SCAN_END: ;
      S_PICK:   cmd.imm = !sts.pick_ok;
      S_READ:   cmd.rd_tgt = 1'b1;
      S_EVAL:   cmd.eval = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: design/ric_dp.sv
module ric_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ric_pkg::cmd_t              cmd,
  output ric_pkg::sts_t              sts,
  input  logic [1:0]                 in_opcode,
  input  logic [ric_pkg::DEV_W-1:0]  in_device_id,
  input  logic [ric_pkg::INO_W-1:0]  in_inode_number,
  input  logic [ric_pkg::SLOT_W-1:0] in_slot,
  input  logic                       in_links_zero,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ric_pkg::STAT_W-1:0] out_status,
  output logic [ric_pkg::SLOT_W-1:0] out_slot_out,
  output logic                       out_victim_writeback,
  output logic [ric_pkg::DEV_W-1:0]  out_victim_device,
  output logic [ric_pkg::INO_W-1:0]  out_victim_inode,
  output logic [ric_pkg::REF_W-1:0]  out_ref_count
);
  import ric_pkg::*;

  // captured item
  opcode_t           op_r;
  logic [DEV_W-1:0]  dev_r;
  logic [INO_W-1:0]  ino_r;
  logic [SLOT_W-1:0] slot_r;
  logic              lz_r;

  // scan bookkeeping
  logic [IDX_W-1:0]  cnt_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              hit_found_r, fa_found_r, fb_found_r;
  logic [IDX_W-1:0]  hit_idx_r, fa_idx_r, fb_idx_r;
  logic [IDX_W-1:0]  search_start_r;

  // result of the current item
  status_t           res_st_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_wb_r;
  logic [DEV_W-1:0]  res_vdev_r;
  logic [INO_W-1:0]  res_vino_r;
  logic [REF_W-1:0]  res_ref_r;

  // output register
  logic              out_vld_r;
  status_t           out_st_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_wb_r;
  logic [DEV_W-1:0]  out_vdev_r;
  logic [INO_W-1:0]  out_vino_r;
  logic [REF_W-1:0]  out_ref_r;

  entry_t            rd_e;
  entry_t            wr_e;
  logic              wr_en;
  logic [IDX_W-1:0]  ram_addr;
  logic [IDX_W-1:0]  tgt_idx;
  logic [IDX_W-1:0]  rr_idx;
  logic              tag_ok;
  logic              slot_ok;
  logic              chk_free;
  logic              chk_match;
  logic              out_free;

  status_t           ev_st;
  logic              ev_wb;
  logic [DEV_W-1:0]  ev_vdev;
  logic [INO_W-1:0]  ev_vino;
  logic [REF_W-1:0]  ev_ref;
  logic [REF_W-1:0]  dec_ref;
  status_t           im_st;
  logic [SLOT_W-1:0] im_slot;

  assign tag_ok   = (dev_r != '0) && (ino_r != '0);
  assign slot_ok  = 32'(slot_r) < 32'(ENTRIES);
  assign rr_idx   = fa_found_r ? fa_idx_r : fb_idx_r;
  assign tgt_idx  = (op_r == OP_ACQUIRE) ? (hit_found_r ? hit_idx_r : rr_idx)
                                         : IDX_W'(slot_r);
  assign ram_addr = (cmd.clr || cmd.scan) ? cnt_r : tgt_idx;
  assign out_free = !out_vld_r || out_ready;

  assign chk_free  = rd_e.refs == '0;
  assign chk_match = (rd_e.dev == dev_r) && (rd_e.ino == ino_r);

  assign sts.clr_last  = cnt_r == LAST_IDX;
  assign sts.scan_last = cnt_r == LAST_IDX;
  assign sts.dec_scan  = (op_r == OP_ACQUIRE) && tag_ok;
  assign sts.dec_slot  = ((op_r == OP_RELEASE) || (op_r == OP_MARK)) && slot_ok;
  assign sts.pick_ok   = hit_found_r || fa_found_r || fb_found_r;
  assign sts.out_free  = out_free;

  ric_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .re    (cmd.scan || cmd.rd_tgt),
    .addr  (ram_addr),
    .wdata (wr_e),
    .rdata (rd_e)
  );

  assign dec_ref = rd_e.refs - REF_W'(1);

  // entry clear, and entry update and result for an item that read its entry
  always_comb begin
    wr_e    = rd_e;
    wr_en   = cmd.clr;
    ev_st   = RS_NOT_HELD;
    ev_wb   = 1'b0;
    ev_vdev = '0;
    ev_vino = '0;
    ev_ref  = '0;
    if (cmd.clr) begin
      wr_e = '0;
    end else if (cmd.eval) begin
      unique case (op_r)
        OP_ACQUIRE: begin
          wr_en = 1'b1;
          if (hit_found_r) begin
            ev_st = RS_HIT;
            ev_ref = (rd_e.refs == REF_MAX) ? rd_e.refs : rd_e.refs + REF_W'(1);
            wr_e.refs = ev_ref;
          end else begin
            ev_st  = RS_MISS;
            ev_ref = REF_W'(1);
            ev_wb  = rd_e.dirty;
            if (rd_e.dirty) begin
              ev_vdev = rd_e.dev;
              ev_vino = rd_e.ino;
            end
            wr_e.dev   = dev_r;
            wr_e.ino   = ino_r;
            wr_e.refs  = REF_W'(1);
            wr_e.dirty = 1'b0;
          end
        end
        OP_RELEASE: begin
          if (!chk_free) begin
            wr_en     = 1'b1;
            ev_ref    = dec_ref;
            wr_e.refs = dec_ref;
            ev_st     = RS_RELEASED;
            if (dec_ref == '0) begin
              if (lz_r) begin
                wr_e.dev   = '0;
                wr_e.ino   = '0;
                wr_e.dirty = 1'b0;
                ev_st      = RS_REL_FREE;
              end else if (rd_e.dirty) begin
                wr_e.dirty = 1'b0;
                ev_st      = RS_REL_WB;
              end
            end
          end
        end
        OP_MARK: begin
          if (!chk_free) begin
            wr_en      = 1'b1;
            wr_e.dirty = 1'b1;
            ev_st      = RS_HIT;
            ev_ref     = rd_e.refs;
          end
        end
        default: ev_st = RS_BAD_TAG;
      endcase
    end
  end

  // results that need no entry
  always_comb begin
    im_st   = RS_BAD_TAG;
    im_slot = '0;
    unique case (op_r) inside
      OP_ACQUIRE: im_st = tag_ok ? RS_FULL : RS_BAD_TAG;
      OP_RELEASE, OP_MARK: begin
        im_st   = RS_NOT_HELD;
        im_slot = slot_r;
      end
      default: im_st = RS_BAD_TAG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_opcode);
      dev_r  <= in_device_id;
      ino_r  <= in_inode_number;
      slot_r <= in_slot;
      lz_r   <= in_links_zero;
    end
    if (cmd.scan) begin
      chk_idx_r <= cnt_r;
    end
    if (chk_vld_r) begin
      if (chk_match && !hit_found_r) hit_idx_r <= chk_idx_r;
      if (chk_free && chk_idx_r >= search_start_r && !fa_found_r) fa_idx_r <= chk_idx_r;
      if (chk_free && !fb_found_r) fb_idx_r <= chk_idx_r;
    end
    if (cmd.eval) begin
      res_st_r   <= ev_st;
      res_slot_r <= SLOT_W'(tgt_idx);
      res_wb_r   <= ev_wb;
      res_vdev_r <= ev_vdev;
      res_vino_r <= ev_vino;
      res_ref_r  <= ev_ref;
    end else if (cmd.imm) begin
      res_st_r   <= im_st;
      res_slot_r <= im_slot;
      res_wb_r   <= 1'b0;
      res_vdev_r <= '0;
      res_vino_r <= '0;
      res_ref_r  <= '0;
    end
    if (cmd.finish && out_free) begin
      out_st_r   <= res_st_r;
      out_slot_r <= res_slot_r;
      out_wb_r   <= res_wb_r;
      out_vdev_r <= res_vdev_r;
      out_vino_r <= res_vino_r;
      out_ref_r  <= res_ref_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r          <= '0;
      chk_vld_r      <= 1'b0;
      hit_found_r    <= 1'b0;
      fa_found_r     <= 1'b0;
      fb_found_r     <= 1'b0;
      search_start_r <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      chk_vld_r <= cmd.scan;
      if (cmd.load) begin
        cnt_r       <= '0;
        hit_found_r <= 1'b0;
        fa_found_r  <= 1'b0;
        fb_found_r  <= 1'b0;
      end else if (cmd.clr || cmd.scan) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + IDX_W'(1);
      end
      if (chk_vld_r) begin
        if (chk_match) hit_found_r <= 1'b1;
        if (chk_free && chk_idx_r >= search_start_r) fa_found_r <= 1'b1;
        if (chk_free) fb_found_r <= 1'b1;
      end
      // a miss moves the round-robin start to the victim
      if (cmd.eval && op_r == OP_ACQUIRE && !hit_found_r) begin
        search_start_r <= tgt_idx;
      end
      if (cmd.finish && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_vld_r;
  assign out_status           = out_st_r;
  assign out_slot_out         = out_slot_r;
  assign out_victim_writeback = out_wb_r;
  assign out_victim_device    = out_vdev_r;
  assign out_victim_inode     = out_vino_r;
  assign out_ref_count        = out_ref_r;

endmodule

FILE: design/refcounted_inode_cache_table_unit.sv
// channel  | dir | handshake          | beat
// in_ch    | in  | valid/ready        | opcode, device_id, inode_number, slot, links_zero
// out_ch   | out | valid/ready        | status, slot_out, victim_writeback, victim_device,
//          |     |                    | victim_inode, ref_count
// An acquire with a good tag makes one pass over the table through the single RAM port,
// which finds the tag and the round-robin free entry. One item is in work at a time.
// After reset a clearing pass writes every entry before in_ch.ready rises.
// A held result sits in the output register; the next item is taken meanwhile and
// waits only at its own finish for out_ch to drain.
module refcounted_inode_cache_table_unit (
  input logic       clk,
  input logic       rst_n,
  ric_in_if.sink    in_ch,
  ric_out_if.source out_ch
);
  import ric_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ric_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ric_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_ch.opcode),
    .in_device_id         (in_ch.device_id),
    .in_inode_number      (in_ch.inode_number),
    .in_slot              (in_ch.slot),
    .in_links_zero        (in_ch.links_zero),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_slot_out         (out_ch.slot_out),
    .out_victim_writeback (out_ch.victim_writeback),
    .out_victim_device    (out_ch.victim_device),
    .out_victim_inode     (out_ch.victim_inode),
    .out_ref_count        (out_ch.ref_count)
  );

endmodule

FILE: test/tb_refcounted_inode_cache_table_unit.sv
module tb_refcounted_inode_cache_table_unit;
  import ric_pkg::*;

  localparam int CYCLE_LIMIT    = 400_000;
  localparam int POOL_DEVS      = 6;
  localparam int POOL_INOS      = 8;
  localparam int POOL_SIZE      = POOL_DEVS * POOL_INOS;
  localparam int RANDOM_REQS    = 1100;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct {
    opcode_t            op;
    logic [DEV_W-1:0]   dev;
    logic [INO_W-1:0]   ino;
    logic [SLOT_W-1:0]  slot;
    logic               links_zero;
    int                 gap;
  } cache_req_t;

  typedef struct {
    status_t            st;
    logic [SLOT_W-1:0]  slot;
    logic               wb;
    logic [DEV_W-1:0]   vdev;
    logic [INO_W-1:0]   vino;
    logic [REF_W-1:0]   cnt;
  } cache_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ric_in_if  in_ch ();
  ric_out_if out_ch ();

  refcounted_inode_cache_table_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the cache table
  logic [DEV_W-1:0]  shadow_dev  [ENTRIES];
  logic [INO_W-1:0]  shadow_ino  [ENTRIES];
  logic [REF_W-1:0]  shadow_refs [ENTRIES];
  logic              shadow_dirty[ENTRIES];
  int                rr_start;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_replies[$];

  logic [DEV_W-1:0] pool_dev[POOL_DEVS];
  logic [INO_W-1:0] pool_ino[POOL_INOS];

  int error_count = 0;
  int cycle_count = 0;
  bit tx_calm     = 1'b0;
  bit tx_busy     = 1'b0;

  function automatic cache_rsp_t cache_lookup_apply(cache_req_t r);
    cache_rsp_t o;
    int hit;
    int idx;
    bit found;
    o.st   = RS_BAD_TAG;
    o.slot = '0;
    o.wb   = 1'b0;
    o.vdev = '0;
    o.vino = '0;
    o.cnt  = '0;
    hit    = -1;
    idx    = rr_start;
    found  = 1'b0;
    case (r.op)
      OP_ACQUIRE: begin
        if (r.dev == '0 || r.ino == '0) return o;
        for (int i = 0; i < ENTRIES; i++)
          if (hit < 0 && shadow_dev[i] == r.dev && shadow_ino[i] == r.ino) hit = i;
        if (hit >= 0) begin
          if (shadow_refs[hit] != REF_MAX) shadow_refs[hit]++;
          o.st   = RS_HIT;
          o.slot = SLOT_W'(hit);
          o.cnt  = shadow_refs[hit];
          return o;
        end
        for (int n = 0; n < ENTRIES; n++) begin
          if (!found) begin
            if (shadow_refs[idx] == '0) found = 1'b1;
            else idx = (idx + 1) % ENTRIES;
          end
        end
        if (!found) begin
          o.st = RS_FULL;
          return o;
        end
        rr_start = idx;
        o.st   = RS_MISS;
        o.slot = SLOT_W'(idx);
        o.cnt  = REF_W'(1);
        if (shadow_dirty[idx]) begin
          o.wb   = 1'b1;
          o.vdev = shadow_dev[idx];
          o.vino = shadow_ino[idx];
        end
        shadow_dev[idx]   = r.dev;
        shadow_ino[idx]   = r.ino;
        shadow_dirty[idx] = 1'b0;
        shadow_refs[idx]  = REF_W'(1);
      end
      OP_RELEASE: begin
        o.slot = r.slot;
        if (int'(r.slot) >= ENTRIES || shadow_refs[r.slot] == '0) begin
          o.st = RS_NOT_HELD;
          return o;
        end
        shadow_refs[r.slot]--;
        o.st = RS_RELEASED;
        if (shadow_refs[r.slot] == '0) begin
          if (r.links_zero) begin
            // unlinked inode: drop the tag so it can no longer hit
            shadow_dev[r.slot]   = '0;
            shadow_ino[r.slot]   = '0;
            shadow_dirty[r.slot] = 1'b0;
            o.st = RS_REL_FREE;
          end else if (shadow_dirty[r.slot]) begin
            shadow_dirty[r.slot] = 1'b0;
            o.st = RS_REL_WB;
          end
        end
        o.cnt = shadow_refs[r.slot];
      end
      OP_MARK: begin
        o.slot = r.slot;
        if (int'(r.slot) >= ENTRIES || shadow_refs[r.slot] == '0) begin
          o.st = RS_NOT_HELD;
          return o;
        end
        shadow_dirty[r.slot] = 1'b1;
        o.st  = RS_HIT;
        o.cnt = shadow_refs[r.slot];
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver
  cache_req_t tx_cur;
  int         tx_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_busy = 1'b0;
      tx_wait = 0;
      in_ch.valid        <= 1'b0;
      in_ch.opcode       <= '0;
      in_ch.device_id    <= '0;
      in_ch.inode_number <= '0;
      in_ch.slot         <= '0;
      in_ch.links_zero   <= 1'b0;
    end else begin
      if (tx_busy && in_ch.ready) begin
        expected_replies.push_back(cache_lookup_apply(tx_cur));
        tx_busy = 1'b0;
        tx_wait = tx_cur.gap;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_reqs.size() > 0) begin
          tx_cur  = pending_reqs.pop_front();
          tx_busy = 1'b1;
          in_ch.opcode       <= tx_cur.op;
          in_ch.device_id    <= tx_cur.dev;
          in_ch.inode_number <= tx_cur.ino;
          in_ch.slot         <= tx_cur.slot;
          in_ch.links_zero   <= tx_cur.links_zero;
        end
      end
      in_ch.valid <= tx_busy;
    end
  end

  // monitor and checker
  int rx_beats    = 0;
  int rx_stall    = 0;
  int rx_hold_cnt = 0;
  bit rx_hold_on  = 1'b0;

  // long hold-off window, counted on its own
  always @(posedge clk) begin
    if (rx_hold_on && rx_hold_cnt < RX_HOLD_CYCLES) rx_hold_cnt <= rx_hold_cnt + 1;
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result beat: expected none actual status %0d",
                   $time, out_ch.status);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.st), 32'(out_ch.status));
          check_field("slot_out", 32'(want.slot), 32'(out_ch.slot_out));
          check_field("victim_writeback", 32'(want.wb), 32'(out_ch.victim_writeback));
          check_field("victim_device", 32'(want.vdev), 32'(out_ch.victim_device));
          check_field("victim_inode", want.vino, out_ch.victim_inode);
          check_field("ref_count", 32'(want.cnt), 32'(out_ch.ref_count));
        end
        rx_beats++;
        if (rx_beats == 60 && !rx_hold_on) begin
          // long hold-off: the block fills and backs up its input
          rx_hold_on = 1'b1;
        end
        if ((rx_beats / 50) % 3 == 0) rx_stall = 0;
        else rx_stall = $urandom_range(0, 12);
      end
      if (rx_hold_on && rx_hold_cnt < RX_HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(opcode_t op, logic [DEV_W-1:0] dev, logic [INO_W-1:0] ino,
                           logic [SLOT_W-1:0] slot, logic lz);
    cache_req_t r;
    r.op         = op;
    r.dev        = dev;
    r.ino        = ino;
    r.slot       = slot;
    r.links_zero = lz;
    r.gap        = tx_calm ? 0 : $urandom_range(0, 12);
    while (pending_reqs.size() >= 2) @(posedge clk);
    pending_reqs.push_back(r);
  endtask

  function automatic logic [SLOT_W-1:0] pick_held_slot();
    int held[$];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_refs[i] != '0) held.push_back(i);
    if (held.size() == 0) return SLOT_W'($urandom_range(0, ENTRIES - 1));
    return SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
  endfunction

  // acquire-heavy and release-heavy phases alternate so the table both fills and drains
  task automatic gen_random_req(bit acquire_heavy);
    int roll;
    int k;
    logic [DEV_W-1:0]  dev;
    logic [INO_W-1:0]  ino;
    logic [SLOT_W-1:0] slot;
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, POOL_SIZE - 1);
    dev  = pool_dev[k % POOL_DEVS];
    ino  = pool_ino[k / POOL_DEVS];
    slot = ($urandom_range(0, 9) < 8) ? pick_held_slot() : SLOT_W'($urandom);
    if (roll < 3) begin
      queue_req(OP_UNUSED, DEV_W'($urandom), $urandom, SLOT_W'($urandom), 1'($urandom));
    end else if (roll < 6) begin
      // bad tag: one half of the tag is zero
      if ($urandom_range(0, 1)) dev = '0;
      else ino = '0;
      queue_req(OP_ACQUIRE, dev, ino, SLOT_W'($urandom), 1'($urandom));
    end else if (roll < (acquire_heavy ? 70 : 40)) begin
      if ($urandom_range(0, 9) == 0) begin
        dev = DEV_W'($urandom);
        ino = $urandom;
      end
      queue_req(OP_ACQUIRE, dev, ino, SLOT_W'($urandom), 1'($urandom));
    end else if (roll < (acquire_heavy ? 85 : 80)) begin
      queue_req(OP_RELEASE, DEV_W'($urandom), $urandom, slot, 1'($urandom));
    end else begin
      queue_req(OP_MARK, DEV_W'($urandom), $urandom, slot, 1'($urandom));
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.opcode       = '0;
    in_ch.device_id    = '0;
    in_ch.inode_number = '0;
    in_ch.slot         = '0;
    in_ch.links_zero   = 1'b0;
    out_ch.ready       = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_dev[i]   = '0;
      shadow_ino[i]   = '0;
      shadow_refs[i]  = '0;
      shadow_dirty[i] = 1'b0;
    end
    rr_start = 0;
    // tags share devices and inodes so partial matches are common
    pool_dev[0] = '1;
    pool_dev[1] = 16'd1;
    for (int i = 2; i < POOL_DEVS; i++) pool_dev[i] = DEV_W'($urandom_range(1, 65535));
    pool_ino[0] = '1;
    pool_ino[1] = 32'd1;
    for (int i = 2; i < POOL_INOS; i++) begin
      pool_ino[i] = $urandom;
      if (pool_ino[i] == '0) pool_ino[i] = 32'h8000_0000;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_req(OP_ACQUIRE, 16'd0, 32'h1234_5678, 5'd0, 1'b0);
    queue_req(OP_ACQUIRE, 16'hFFFF, 32'd0, 5'd31, 1'b1);
    queue_req(OP_UNUSED, '1, '1, '1, 1'b1);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd0, 1'b0);
    queue_req(OP_MARK, 16'd0, 32'd0, 5'd31, 1'b1);
    queue_req(OP_ACQUIRE, '1, '1, 5'd0, 1'b0);
    queue_req(OP_ACQUIRE, '1, '1, 5'd0, 1'b0);
    queue_req(OP_ACQUIRE, 16'd1, 32'd1, 5'd0, 1'b0);
    queue_req(OP_ACQUIRE, '1, 32'd1, 5'd0, 1'b0);
    queue_req(OP_ACQUIRE, 16'd1, '1, 5'd0, 1'b0);
    queue_req(OP_MARK, 16'd0, 32'd0, 5'd1, 1'b0);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd1, 1'b0);
    queue_req(OP_MARK, 16'd0, 32'd0, 5'd1, 1'b0);
    queue_req(OP_MARK, 16'd0, 32'd0, 5'd0, 1'b0);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd0, 1'b1);
    // count is zero but the tag stays: still a hit
    queue_req(OP_ACQUIRE, 16'd1, 32'd1, 5'd0, 1'b0);
    queue_req(OP_MARK, 16'd0, 32'd0, 5'd1, 1'b0);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd1, 1'b1);
    queue_req(OP_ACQUIRE, 16'd1, 32'd1, 5'd0, 1'b0);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd0, 1'b0);
    queue_req(OP_RELEASE, 16'd0, 32'd0, 5'd1, 1'b0);
    queue_req(OP_RELEASE, '1, '1, 5'd31, 1'b1);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      tx_calm = ((n / 40) % 3 == 0);
      gen_random_req(((n / 100) % 2) == 0);
    end

    // drain, then release a few held entries
    while (pending_reqs.size() > 0 || tx_busy || expected_replies.size() > 0)
      @(posedge clk);
    tx_calm = 1'b0;
    for (int n = 0; n < 4; n++)
      queue_req(OP_RELEASE, '0, '0, pick_held_slot(), 1'($urandom));

    while (pending_reqs.size() > 0 || tx_busy) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
